>>> rtl/wtlc_pkg.sv
// ----------------------------------------------------------------------------
// wtlc_pkg
// Shared types and constants for the write-through LRU cache unit.
// ----------------------------------------------------------------------------
package wtlc_pkg;

	localparam int OP_W       = 2;
	localparam int KEY_W      = 16;
	localparam int WORD_W     = 32;
	localparam int CNTR_W     = 32;
	localparam int CAP_W      = 5;
	localparam int TIME_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// operation codes
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CACHE_TIME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_TIME = 2'd2;

	// configuration reset values
	localparam logic [CAP_W-1:0]  CAPACITY_RESET    = 5'd16;
	localparam logic [TIME_W-1:0] CACHE_TIME_RESET  = 8'd1;
	localparam logic [TIME_W-1:0] MEMORY_TIME_RESET = 8'd10;

	// controller -> datapath
	typedef struct packed {
		logic start;   // capture transaction, clear scan results
		logic scan;    // issue one entry read, advance scan index
		logic commit;  // apply update, load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;  // current scan index is the last entry
	} sts_t;

endpackage

>>> rtl/wtlc_ctrl.sv
// ----------------------------------------------------------------------------
// wtlc_ctrl
// Sequencer: accept, scan all entries, drain, commit when result register free.
// ----------------------------------------------------------------------------
module wtlc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output wtlc_pkg::cmd_t cmd,
	input  wtlc_pkg::sts_t sts
);
	import wtlc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/wtlc_datapath.sv
// ----------------------------------------------------------------------------
// wtlc_datapath
// Tag/data memories, per-entry valid and age, scan results, counters, result.
// ----------------------------------------------------------------------------
module wtlc_datapath #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wtlc_pkg::cmd_t                     cmd,
	output wtlc_pkg::sts_t                     sts,
	input  logic                               cfg_we,
	input  logic [wtlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wtlc_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [wtlc_pkg::OP_W-1:0]          operation,
	input  logic [wtlc_pkg::KEY_W-1:0]         key,
	input  logic signed [wtlc_pkg::WORD_W-1:0] value,
	input  logic                               present,
	output logic                               hit,
	output logic signed [wtlc_pkg::WORD_W-1:0] data,
	output logic                               mem_read_req,
	output logic                               mem_write_req,
	output logic [wtlc_pkg::KEY_W-1:0]         mem_addr,
	output logic signed [wtlc_pkg::WORD_W-1:0] mem_data,
	output logic [wtlc_pkg::CNTR_W-1:0]        total_latency,
	output logic [wtlc_pkg::CNTR_W-1:0]        read_hit_count,
	output logic [wtlc_pkg::CNTR_W-1:0]        read_miss_count,
	output logic [wtlc_pkg::CNTR_W-1:0]        write_count
);
	import wtlc_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AGE_W = IDX_W;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int TAG_W = (ADDR_BITS < KEY_W) ? ADDR_BITS : KEY_W;
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// configuration
	logic [CAP_W-1:0]  cap_q;
	logic [TIME_W-1:0] cache_time_q;
	logic [TIME_W-1:0] mem_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAPACITY_RESET;
			cache_time_q <= CACHE_TIME_RESET;
			mem_time_q   <= MEMORY_TIME_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CAPACITY:    cap_q        <= cfg_data[CAP_W-1:0];
				CFG_CACHE_TIME:  cache_time_q <= cfg_data[TIME_W-1:0];
				CFG_MEMORY_TIME: mem_time_q   <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// captured transaction
	logic [OP_W-1:0]   op_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WORD_W-1:0] value_q;
	logic              present_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q      <= operation;
			tag_q     <= key[TAG_W-1:0];
			value_q   <= value;
			present_q <= present;
		end
	end

	// scan index
	logic [IDX_W-1:0] rd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.start) begin
			rd_idx_q <= '0;
		end else if (cmd.scan) begin
			rd_idx_q <= rd_idx_q + IDX_W'(1);
		end
	end

	assign sts.scan_last = (rd_idx_q == IDX_W'(ENTRIES - 1));

	// tag and data memories
	logic [TAG_W-1:0]  tag_mem  [ENTRIES];
	logic [WORD_W-1:0] data_mem [ENTRIES];
	logic [TAG_W-1:0]  tag_s1;
	logic [WORD_W-1:0] data_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              vld_s1;
	logic              mem_we;
	logic [IDX_W-1:0]  wr_idx;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[wr_idx]  <= tag_q;
			data_mem[wr_idx] <= value_q;
		end
		if (cmd.scan) begin
			tag_s1  <= tag_mem[rd_idx_q];
			data_s1 <= data_mem[rd_idx_q];
			idx_s1  <= rd_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan;
		end
	end

	// per-entry valid and age
	logic [ENTRIES-1:0] valid_q;
	logic [AGE_W-1:0]   age_q [ENTRIES];
	logic               ent_v;
	logic [AGE_W-1:0]   ent_age;

	assign ent_v   = valid_q[idx_s1];
	assign ent_age = age_q[idx_s1];

	// scan results
	logic              match_q;
	logic [IDX_W-1:0]  match_idx_q;
	logic [AGE_W-1:0]  match_age_q;
	logic [WORD_W-1:0] match_data_q;
	logic [CNT_W-1:0]  used_q;
	logic              victim_found_q;
	logic [IDX_W-1:0]  victim_idx_q;
	logic [AGE_W-1:0]  victim_age_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q        <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
			used_q         <= '0;
		end else if (cmd.start) begin
			match_q        <= 1'b0;
			victim_found_q <= 1'b0;
			free_found_q   <= 1'b0;
			used_q         <= '0;
		end else if (vld_s1) begin
			if (ent_v) begin
				used_q <= used_q + CNT_W'(1);
				if (tag_s1 == tag_q) begin
					match_q      <= 1'b1;
					match_idx_q  <= idx_s1;
					match_age_q  <= ent_age;
					match_data_q <= data_s1;
				end
				if (!victim_found_q || ent_age > victim_age_q) begin
					victim_found_q <= 1'b1;
					victim_idx_q   <= idx_s1;
					victim_age_q   <= ent_age;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
		end
	end

	// commit decisions
	logic             is_read;
	logic             is_store;
	logic             touch;
	logic             insert;
	logic             evict;
	logic [CW-1:0]    cap_ext;
	logic [CW-1:0]    cap_eff;
	logic [IDX_W-1:0] slot_idx;
	logic [TIME_W:0]  lat_add;

	assign is_read  = (op_q == OP_READ);
	assign is_store = (op_q == OP_WRITE) || ((op_q == OP_FILL) && present_q);
	assign touch    = match_q && (is_read || is_store);
	assign insert   = is_store && !match_q;
	assign cap_ext  = CW'(cap_q);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CW'(1);
		end else if (cap_ext > CW'(ENTRIES)) begin
			cap_eff = CW'(ENTRIES);
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign evict = insert && (CW'(used_q) >= cap_eff);

	// lowest free slot, counting a victim freed by this insert
	assign slot_idx = (free_found_q && (!evict || free_idx_q < victim_idx_q)) ?
		free_idx_q : victim_idx_q;

	assign mem_we = cmd.commit && (insert || (touch && is_store));
	assign wr_idx = insert ? slot_idx : match_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				age_q[j] <= '0;
			end
		end else if (cmd.commit) begin
			for (int j = 0; j < ENTRIES; j++) begin
				if (touch) begin
					if (IDX_W'(j) == match_idx_q) begin
						age_q[j] <= '0;
					end else if (valid_q[j] && age_q[j] < match_age_q) begin
						age_q[j] <= age_q[j] + AGE_W'(1);
					end
				end else if (insert) begin
					if (IDX_W'(j) == slot_idx) begin
						valid_q[j] <= 1'b1;
						age_q[j]   <= '0;
					end else if (evict && IDX_W'(j) == victim_idx_q) begin
						valid_q[j] <= 1'b0;
					end else if (valid_q[j]) begin
						age_q[j] <= age_q[j] + AGE_W'(1);
					end
				end
			end
		end
	end

	// latency and event counters
	always_comb begin
		if (is_read) begin
			lat_add = {1'b0, cache_time_q} + (match_q ? '0 : {1'b0, mem_time_q});
		end else if (is_store) begin
			lat_add = {1'b0, cache_time_q} + {1'b0, mem_time_q};
		end else begin
			lat_add = '0;
		end
	end

	logic [CNTR_W-1:0] latency_q;
	logic [CNTR_W-1:0] hits_q;
	logic [CNTR_W-1:0] misses_q;
	logic [CNTR_W-1:0] writes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latency_q <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			writes_q  <= '0;
		end else if (cmd.commit) begin
			latency_q <= latency_q + CNTR_W'(lat_add);
			if (is_read && match_q) begin
				hits_q <= hits_q + CNTR_W'(1);
			end
			if (is_read && !match_q) begin
				misses_q <= misses_q + CNTR_W'(1);
			end
			if (is_store) begin
				writes_q <= writes_q + CNTR_W'(1);
			end
		end
	end

	// result register
	logic              hit_q;
	logic [WORD_W-1:0] data_q;
	logic              rreq_q;
	logic              wreq_q;
	logic [KEY_W-1:0]  addr_q;
	logic [WORD_W-1:0] wdata_q;

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q   <= is_read && match_q;
			data_q  <= (is_read && match_q) ? match_data_q : '0;
			rreq_q  <= is_read && !match_q;
			wreq_q  <= is_store;
			addr_q  <= ((is_read && !match_q) || is_store) ? KEY_W'(tag_q) : '0;
			wdata_q <= is_store ? value_q : '0;
		end
	end

	assign hit             = hit_q;
	assign data            = data_q;
	assign mem_read_req    = rreq_q;
	assign mem_write_req   = wreq_q;
	assign mem_addr        = addr_q;
	assign mem_data        = wdata_q;
	assign total_latency   = latency_q;
	assign read_hit_count  = hits_q;
	assign read_miss_count = misses_q;
	assign write_count     = writes_q;

endmodule

>>> rtl/write_through_lru_cache_unit.sv
// ----------------------------------------------------------------------------
// write_through_lru_cache_unit
// Fully associative write-through cache with LRU replacement and counters.
// ----------------------------------------------------------------------------
//
// Channel   Handshake               Payload
// -------   ---------------------   ---------------------------------------
// input     in_valid / in_ready     operation, key, value, present
// output    out_valid / out_ready   hit, data, mem_read_req, mem_write_req,
//                                   mem_addr, mem_data, total_latency,
//                                   read_hit_count, read_miss_count,
//                                   write_count
// config    cfg_valid / cfg_ready   cfg_index, cfg_data (always ready)
//
// Each transaction runs from acceptance to the next acceptance in steps:
// the tag/data memories are swept one entry per cycle (single read port),
// a drain step empties the read stage, and a commit step applies the update
// and loads the result register.
// A new transaction may be accepted while the previous result still waits;
// the commit stalls until the result register is taken.
// Reset clears valid marks, ages and counters and reloads the configuration
// reset values at once; there is no clearing pass.
//
// Scan collects the matching entry, the occupancy, the oldest valid entry
// (eviction victim) and the lowest free slot. Commit then touches the hit
// entry (younger entries age by one) or, on a store miss, inserts a new
// entry at age zero, aging other valid entries, evicting the oldest if full.
module write_through_lru_cache_unit #(
	parameter int ENTRIES   = 16,
	parameter int ADDR_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration writes
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wtlc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [wtlc_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input transactions
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wtlc_pkg::OP_W-1:0]          operation,
	input  logic [wtlc_pkg::KEY_W-1:0]         key,
	input  logic signed [wtlc_pkg::WORD_W-1:0] value,
	input  logic                               present,
	// result transactions
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               hit,
	output logic signed [wtlc_pkg::WORD_W-1:0] data,
	output logic                               mem_read_req,
	output logic                               mem_write_req,
	output logic [wtlc_pkg::KEY_W-1:0]         mem_addr,
	output logic signed [wtlc_pkg::WORD_W-1:0] mem_data,
	output logic [wtlc_pkg::CNTR_W-1:0]        total_latency,
	output logic [wtlc_pkg::CNTR_W-1:0]        read_hit_count,
	output logic [wtlc_pkg::CNTR_W-1:0]        read_miss_count,
	output logic [wtlc_pkg::CNTR_W-1:0]        write_count
);
	import wtlc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// config registers must only be written while idle (the block does not enforce this), so no backpressure
	assign cfg_ready = 1'b1;

	wtlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wtlc_datapath #(
		.ENTRIES   (ENTRIES),
		.ADDR_BITS (ADDR_BITS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.operation       (operation),
		.key             (key),
		.value           (value),
		.present         (present),
		.hit             (hit),
		.data            (data),
		.mem_read_req    (mem_read_req),
		.mem_write_req   (mem_write_req),
		.mem_addr        (mem_addr),
		.mem_data        (mem_data),
		.total_latency   (total_latency),
		.read_hit_count  (read_hit_count),
		.read_miss_count (read_miss_count),
		.write_count     (write_count)
	);

endmodule
